### hw/rtl/capacitated_choice_matcher_unit_assert.svh
// Assertion macros for the capacitated choice matcher.
// Each use samples on the rising edge of clk and is held off while rst_n is low.
`ifndef CAPACITATED_CHOICE_MATCHER_UNIT_ASSERT_SVH
`define CAPACITATED_CHOICE_MATCHER_UNIT_ASSERT_SVH

// Clocked property check with a reset hold-off.
`define CCM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal stays unchanged on the cycle after a condition.
`define CCM_ASSERT_HOLD(name, cond, sig, msg) \
    `CCM_ASSERT(name, (cond) |=> $stable(sig), msg)

`endif

### hw/rtl/ccm_pkg.sv
package ccm_pkg;

    localparam int NUM_CLASSES = 6;
    localparam int CHOICE_W    = 3;
    localparam int SUBSET_W    = NUM_CLASSES;
    localparam int POP_W       = $clog2(NUM_CLASSES + 1);
    // empty, single classes, unordered pairs
    localparam int NUM_TYPES   = 1 + NUM_CLASSES + (NUM_CLASSES * (NUM_CLASSES - 1)) / 2;
    localparam int TYPE_W      = $clog2(NUM_TYPES);
    localparam int CAP_W       = 7;
    localparam int COUNT_W     = 7;

    typedef logic [NUM_CLASSES-1:0] class_mask_t;
    typedef class_mask_t mask_table_t [NUM_TYPES];

    typedef struct packed {
        logic                load;
        logic                init;
        logic                step;
        logic                last_type;
        logic                emit;
        logic [SUBSET_W-1:0] subset;
        logic [SUBSET_W-1:0] next_subset;
        logic [TYPE_W-1:0]   type_idx;
    } ccm_cmd_t;

    function automatic mask_table_t build_type_masks();
        mask_table_t t;
        int          k;
        k = 0;
        t[0] = '0;
        k = 1;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            t[k] = class_mask_t'(1) << i;
            k++;
        end
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            for (int j = i + 1; j < NUM_CLASSES; j++)
            begin
                t[k] = (class_mask_t'(1) << i) | (class_mask_t'(1) << j);
                k++;
            end
        end
        return t;
    endfunction

    localparam mask_table_t TYPE_MASK = build_type_masks();
    localparam logic [TYPE_W-1:0] FIRST_TYPE = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] LAST_TYPE  = TYPE_W'(NUM_TYPES - 1);

    function automatic class_mask_t choice_mask(input logic [CHOICE_W-1:0] c);
        class_mask_t m;
        m = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (c == CHOICE_W'(i))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [TYPE_W-1:0] mask_to_type(input class_mask_t m);
        logic [TYPE_W-1:0] k;
        k = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (TYPE_MASK[i] == m)
            begin
                k = TYPE_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [POP_W-1:0] class_pop(input class_mask_t m);
        logic [POP_W-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            p = p + POP_W'(m[i]);
        end
        return p;
    endfunction

endpackage

### hw/rtl/ccm_ctrl.sv
module ccm_ctrl
    import ccm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    input  logic     out_busy,
    output logic     in_ready,
    output ccm_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SOLVE,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [SUBSET_W-1:0] subset_reg, subset_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic                in_fire;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.load        = in_fire;
        cmd.init        = in_fire && in_last;
        cmd.step        = (state_reg == ST_SOLVE);
        cmd.last_type   = (type_reg == LAST_TYPE);
        cmd.emit        = (state_reg == ST_EMIT) && !out_busy;
        cmd.subset      = subset_reg;
        cmd.next_subset = subset_reg + SUBSET_W'(1);
        cmd.type_idx    = type_reg;

        state_next  = state_reg;
        subset_next = subset_reg;
        type_next   = type_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_last)
                begin
                    state_next  = ST_SOLVE;
                    subset_next = '0;
                    type_next   = FIRST_TYPE;
                end
            end
            ST_SOLVE:
            begin
                if (type_reg == LAST_TYPE)
                begin
                    type_next   = FIRST_TYPE;
                    subset_next = subset_reg + SUBSET_W'(1);
                    if (subset_reg == '1)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    type_next = type_reg + TYPE_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            subset_reg <= '0;
            type_reg   <= FIRST_TYPE;
        end
        else
        begin
            state_reg  <= state_next;
            subset_reg <= subset_next;
            type_reg   <= type_next;
        end
    end

endmodule

### hw/rtl/ccm_datapath.sv
module ccm_datapath
    import ccm_pkg::*;
#(
    parameter int MAX_REQUESTS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ccm_cmd_t            cmd,
    input  logic [CHOICE_W-1:0] choice_a,
    input  logic [CHOICE_W-1:0] choice_b,
    input  logic [CAP_W-1:0]    capacity,
    output logic [COUNT_W-1:0]  assigned_count,
    output logic                all_assigned
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int PW = CAP_W + POP_W;
    localparam int AW = CW + PW + 1;

    // requests per class-set type, and the request total
    logic [CW-1:0] cnt_reg [NUM_TYPES];
    logic [CW-1:0] n_reg;
    // running cut value for the current class subset, and best cut so far
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] best_reg, best_next;

    logic [TYPE_W-1:0] in_type;
    logic              full;
    logic [AW-1:0]     add;
    logic [AW-1:0]     acc_sum;
    logic [PW-1:0]     cap_prod;

    assign in_type  = mask_to_type(choice_mask(choice_a) | choice_mask(choice_b));
    assign full     = (n_reg == CW'(MAX_REQUESTS));
    // a request is cut at the source unless all its classes lie in the subset
    assign add      = ((TYPE_MASK[cmd.type_idx] & ~cmd.subset) != '0)
                      ? AW'(cnt_reg[cmd.type_idx]) : '0;
    assign acc_sum  = acc_reg + add;
    assign cap_prod = PW'(capacity) * PW'(class_pop(cmd.next_subset));

    always_comb
    begin
        acc_next  = acc_reg;
        best_next = best_reg;
        if (cmd.init)
        begin
            acc_next  = '0;
            best_next = '1;
        end
        else if (cmd.step)
        begin
            if (cmd.last_type)
            begin
                if (acc_sum < best_reg)
                begin
                    best_next = acc_sum;
                end
                acc_next = AW'(cap_prod);
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            n_reg    <= '0;
            acc_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            best_reg <= best_next;
            if (cmd.emit)
            begin
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    cnt_reg[i] <= '0;
                end
                n_reg <= '0;
            end
            else if (cmd.load && !full)
            begin
                cnt_reg[in_type] <= cnt_reg[in_type] + CW'(1);
                n_reg            <= n_reg + CW'(1);
            end
        end
    end

    assign assigned_count = best_reg[COUNT_W-1:0];
    assign all_assigned   = (best_reg == AW'(n_reg));

endmodule

### hw/rtl/capacitated_choice_matcher_unit.sv
// Capacitated choice matcher.
// Input stream (s_axis_*): one request per transfer, two acceptable class codes
// in tdata; tlast marks the final request of a set and starts the solve.
// Requests beyond MAX_REQUESTS are dropped but a tlast on them still solves.
// Output stream (m_axis_*): one transfer per set, the maximum number of
// requests that fit the classes under class_capacity, and an all-fit flag.
// cfg_we/cfg_wdata write class_capacity (reset 1); write only while idle.
// Requests load one per transfer while tready is high. The solve evaluates
// the min cut over all 64 class subsets, one request type (21 of them) per
// cycle on one adder, then places the result in the output register when free.
// Input is held off (tready low) from the tlast transfer until the result is
// placed in the output register. A stalled result waits there while the next
// set loads; a further solve holds its result until the register is free.
// Reset clears the request counts and the output valid flag, and sets the capacity to 1.
module capacitated_choice_matcher_unit
    import ccm_pkg::*;
#(
    parameter int MAX_REQUESTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,      // class_capacity
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [2:0] choice_a, [5:3] choice_b, [7:6] zero
    input  logic       s_axis_tlast,   // last_request
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [6:0] assigned_count, [7] all_assigned
);

    ccm_cmd_t           cmd;
    logic [CAP_W-1:0]   capacity_reg;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;
    logic               out_busy;
    logic [COUNT_W-1:0] assigned_count;
    logic               all_assigned;

    // output register can take a result if empty or draining this cycle
    assign out_busy = out_valid_reg && !m_axis_tready;

    ccm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .out_busy (out_busy),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    ccm_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .choice_a       (s_axis_tdata[2:0]),
        .choice_b       (s_axis_tdata[5:3]),
        .capacity       (capacity_reg),
        .assigned_count (assigned_count),
        .all_assigned   (all_assigned)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {all_assigned, assigned_count};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### hw/rtl/ccm_checker.sv
`include "capacitated_choice_matcher_unit_assert.svh"

module ccm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic out_stall;
    logic in_last_xfer;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // a stalled result keeps its payload
    `CCM_ASSERT_HOLD(a_out_hold, out_stall, m_axis_tdata, "result changed while stalled")

    // input closes after the final request of a set
    `CCM_ASSERT(a_last_closes, in_last_xfer |=> !s_axis_tready, "input open after tlast")

    // the solve never completes in the cycle after the final request
    `CCM_ASSERT(a_no_instant, in_last_xfer |=> !$rose(m_axis_tvalid), "result too early")

endmodule

bind capacitated_choice_matcher_unit ccm_checker u_ccm_checker (.*);

### tb/sv/testbench.sv
module testbench;
    import ccm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected solve outcome
    typedef struct {
        logic [COUNT_W-1:0] assigned_count;
        logic               all_assigned;
    } match_result_t;

    localparam int STORE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int CALM_ITEMS    = 150;   // closing stretch with no idling
    localparam int LONG_HOLD     = 4000;  // cycles of receiver hold-off

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_we         = 1'b0;
    logic [6:0] cfg_wdata      = '0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = '0;     // [2:0] choice_a, [5:3] choice_b, [7:6] zero
    logic       s_axis_tlast   = 1'b0;   // last_request
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;            // [6:0] assigned_count, [7] all_assigned

    // Predictor state: class masks of the set being loaded, and the capacity
    class_mask_t   loaded_masks[$];
    int unsigned   capacity_model = 1;
    match_result_t expected_results[$];

    int  error_count  = 0;
    int  items_sent   = 0;
    bit  idle_enable  = 1'b1;
    bit  offering     = 1'b0;  // tvalid currently held high
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    int  stall_left   = 0;

    always #5 clk = ~clk;

    capacitated_choice_matcher_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Max flow equals the min cut. For a set C of classes kept on the source
    // side, a request costs 1 unless all its classes lie in C, and each class
    // in C costs the capacity. A request with no usable class is always free.
    function automatic match_result_t predict_assignment();
        match_result_t r;
        int unsigned   best;
        int unsigned   cut;
        best = 32'hFFFF_FFFF;
        for (int c = 0; c < (1 << NUM_CLASSES); c++)
        begin
            cut = 0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                if (c[i])
                begin
                    cut += capacity_model;
                end
            end
            foreach (loaded_masks[k])
            begin
                if ((loaded_masks[k] & ~class_mask_t'(c)) != '0)
                begin
                    cut++;
                end
            end
            if (cut < best)
            begin
                best = cut;
            end
        end
        r.assigned_count = COUNT_W'(best);
        r.all_assigned   = (best == loaded_masks.size());
        return r;
    endfunction

    function automatic class_mask_t usable_classes(input logic [2:0] a, input logic [2:0] b);
        class_mask_t m;
        m = '0;
        if (a < NUM_CLASSES)
        begin
            m[a] = 1'b1;
        end
        if (b < NUM_CLASSES)
        begin
            m[b] = 1'b1;
        end
        return m;
    endfunction

    // Offer one request and wait for its transfer; the model is updated on it
    task automatic send_request(input logic [2:0] a, input logic [2:0] b, input bit last);
        int gap;
        if (!offering)
        begin
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, b, a};
        s_axis_tlast  <= last;
        offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_sent++;
        if (loaded_masks.size() < STORE_DEPTH)
        begin
            loaded_masks.push_back(usable_classes(a, b));
        end
        if (last)
        begin
            expected_results.push_back(predict_assignment());
            loaded_masks.delete();
        end
        // drop valid for a random gap, and always after the set is closed
        gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0 || last)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [2:0] random_choice();
        if ($urandom_range(0, 9) == 0)
        begin
            return 3'($urandom_range(6, 7));
        end
        return 3'($urandom_range(0, 5));
    endfunction

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_request(random_choice(), random_choice(), i == len - 1);
        end
    endtask

    // Capacity changes only once every solve has been delivered
    task automatic write_capacity(input logic [6:0] value);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity_model = value;
    endtask

    task automatic test_directed();
        // reset capacity is one
        send_request(3'd0, 3'd0, 1'b1);
        send_request(3'd5, 3'd5, 1'b0);
        send_request(3'd5, 3'd5, 1'b1);           // second one cannot fit
        send_request(3'd7, 3'd7, 1'b1);           // no usable class at all
        send_request(3'd6, 3'd2, 1'b0);           // out-of-range code leaves one edge
        send_request(3'd2, 3'd6, 1'b1);
        send_request(3'd0, 3'd1, 1'b0);
        send_request(3'd1, 3'd2, 1'b0);
        send_request(3'd2, 3'd3, 1'b0);
        send_request(3'd3, 3'd4, 1'b0);
        send_request(3'd4, 3'd5, 1'b1);           // needs augmenting reroutes
        write_capacity(7'd0);                     // nothing can be assigned
        send_request(3'd0, 3'd1, 1'b0);
        send_request(3'd4, 3'd3, 1'b1);
        write_capacity(7'd127);
        send_request(3'd3, 3'd3, 1'b0);
        send_request(3'd3, 3'd3, 1'b0);
        send_request(3'd3, 3'd7, 1'b1);
        write_capacity(7'd2);
        send_request(3'd1, 3'd1, 1'b0);
        send_request(3'd1, 3'd1, 1'b0);
        send_request(3'd1, 3'd1, 1'b1);
    endtask

    // Overfull set: extra requests are dropped, the tlast one included
    task automatic test_store_full();
        write_capacity(7'd64);
        send_set(STORE_DEPTH + 6);
        write_capacity(7'd11);
        send_set(STORE_DEPTH);
    endtask

    // Receiver holds off while sets keep coming, so the block backs up
    task automatic test_backpressure();
        write_capacity(7'd3);
        hold_request = 1'b1;
        send_set(5);
        send_set(7);
        send_set(4);
    endtask

    task automatic test_random();
        int len;
        int sets_in_phase;
        sets_in_phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent > RANDOM_ITEMS - CALM_ITEMS)
            begin
                idle_enable = 1'b0;
            end
            if (sets_in_phase == 8)
            begin
                case ($urandom_range(0, 5))
                    0:       write_capacity(7'd0);
                    1:       write_capacity(7'd64);
                    2:       write_capacity(7'($urandom_range(65, 127)));
                    default: write_capacity(7'($urandom_range(1, 12)));
                endcase
                sets_in_phase = 0;
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 24);
            send_set(len);
            sets_in_phase++;
        end
    endtask

    // Result side: random stalls, plus one long hold when requested
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        match_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[6:0] !== exp_r.assigned_count)
                begin
                    report_mismatch($sformatf("assigned_count %0d, expected %0d",
                                              m_axis_tdata[6:0], exp_r.assigned_count));
                end
                if (m_axis_tdata[7] !== exp_r.all_assigned)
                begin
                    report_mismatch($sformatf("all_assigned %b, expected %b",
                                              m_axis_tdata[7], exp_r.all_assigned));
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // A timeout far beyond the slowest correct run
    initial
    begin
        #50_000_000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
